// ===== src/pls_pkg.sv =====
// Package for the packet layer segmenter: shared constants, widths and the
// request record that travels from the front end through the queue to the back end.
// No dependencies.
package pls_pkg;

  localparam int FRAGMENT_DATA_BYTES_DEF = 128;
  localparam int MAX_PACKET_BYTES_DEF    = 4096;

  localparam int PKT_LEN_W = 13;       // width of the packet_length field
  localparam int HDR_MAX   = 4;        // header store entries
  localparam int HSEL_W    = 2;        // index into the header store
  localparam int IDX_W     = 3;        // result index within one request, 0..HDR_MAX

  localparam int HDR_STD   = 3;        // header bytes, standard sequencing
  localparam int HDR_EXT   = 4;        // header bytes, extended sequencing

  localparam int           STD_M_IDX  = 2;
  localparam int           EXT_M_IDX  = 3;
  localparam logic [7:0]   STD_M_MASK = 8'h10;
  localparam logic [7:0]   EXT_M_MASK = 8'h01;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One request: results hdr[0..last_idx-1], then a final result that is
  // either the data byte or hdr[last_idx] (header flush on an early end).
  typedef struct packed {
    logic [HDR_MAX-1:0][7:0] hdr;
    logic [7:0]              data;
    logic [IDX_W-1:0]        last_idx;
    logic                    final_hdr;
    logic                    frag_end;
    logic                    pkt_end;
  } job_t;

endpackage

// ===== src/pls_front.sv =====
// Front end of the packet layer segmenter: takes input bytes, tracks packet
// position, holds the header of a fragmented packet and turns the other bytes into
// requests for the back end. Depends on pls_pkg.
module pls_front #(
  parameter int FRAGMENT_DATA_BYTES = pls_pkg::FRAGMENT_DATA_BYTES_DEF,
  parameter int MAX_PACKET_BYTES    = pls_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_extended_mode,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_first_of_packet,
  input  logic                         in_last_of_packet,
  input  logic [pls_pkg::PKT_LEN_W-1:0] in_packet_length,
  input  logic                         q_full,
  output logic                         q_push,
  output pls_pkg::job_t                q_job
);

  localparam int LEN_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int FILL_W = $clog2(FRAGMENT_DATA_BYTES + 1);
  localparam int CW     = ((LEN_W > pls_pkg::PKT_LEN_W) ? LEN_W : pls_pkg::PKT_LEN_W) + 2;

  logic                ext_r;
  logic                frag_r, frag_nxt;
  logic [LEN_W-1:0]    bp_r, bp_nxt;
  logic [LEN_W-1:0]    lh_r, lh_nxt;
  logic [FILL_W-1:0]   ff_r, ff_nxt;
  logic [7:0]          hdr_r [pls_pkg::HDR_MAX];

  logic                accept;
  logic [pls_pkg::IDX_W-1:0] hl;
  logic [CW-1:0]       len_wide, len_clamp;
  logic                frag_new;
  logic                cur_frag;
  logic [LEN_W-1:0]    cur_bp, cur_lh;
  logic [FILL_W-1:0]   cur_ff;
  logic [pls_pkg::HSEL_W-1:0] bp_lo;
  logic                in_hdr, closing, more, fill_end, fend, hdr_we;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;

  assign hl = ext_r ? pls_pkg::IDX_W'(pls_pkg::HDR_EXT) : pls_pkg::IDX_W'(pls_pkg::HDR_STD);

  // length clamp and fragmentation decision on the first byte
  assign len_wide  = CW'(in_packet_length);
  assign len_clamp = (len_wide > CW'(MAX_PACKET_BYTES)) ? CW'(MAX_PACKET_BYTES) : len_wide;
  assign frag_new  = len_clamp > (CW'(hl) + CW'(FRAGMENT_DATA_BYTES));

  assign cur_frag = in_first_of_packet ? frag_new            : frag_r;
  assign cur_bp   = in_first_of_packet ? '0                  : bp_r;
  assign cur_ff   = in_first_of_packet ? '0                  : ff_r;
  assign cur_lh   = in_first_of_packet ? len_clamp[LEN_W-1:0] : lh_r;
  assign lh_nxt   = cur_lh;

  assign bp_lo    = cur_bp[pls_pkg::HSEL_W-1:0];
  assign in_hdr   = CW'(cur_bp) < CW'(hl);
  assign closing  = in_last_of_packet | ((CW'(cur_bp) + CW'(1)) >= CW'(cur_lh));
  assign more     = (CW'(cur_bp) + CW'(FRAGMENT_DATA_BYTES)) < CW'(cur_lh);
  assign fill_end = cur_ff == FILL_W'(FRAGMENT_DATA_BYTES - 1);
  assign fend     = closing | fill_end;

  always_comb begin
    frag_nxt = cur_frag;
    bp_nxt   = cur_bp;
    ff_nxt   = cur_ff;
    hdr_we   = 1'b0;
    q_push   = 1'b0;
    for (int i = 0; i < pls_pkg::HDR_MAX; i++) begin
      q_job.hdr[i] = hdr_r[i];
    end
    q_job.data      = in_data_byte;
    q_job.last_idx  = '0;
    q_job.final_hdr = 1'b0;
    q_job.frag_end  = in_last_of_packet;
    q_job.pkt_end   = in_last_of_packet;
    if (!cur_frag) begin
      q_push = accept;
    end else if (in_hdr) begin
      hdr_we            = 1'b1;
      bp_nxt            = cur_bp + LEN_W'(1);
      q_job.hdr[bp_lo]  = in_data_byte;
      if (in_last_of_packet) begin
        // packet ended while the header was held: flush what we have
        q_push          = accept;
        q_job.last_idx  = pls_pkg::IDX_W'(bp_lo);
        q_job.final_hdr = 1'b1;
        q_job.frag_end  = 1'b1;
        q_job.pkt_end   = 1'b1;
        frag_nxt        = 1'b0;
        bp_nxt          = '0;
        ff_nxt          = '0;
      end
    end else begin
      q_push = accept;
      if (more) begin
        if (ext_r) begin
          q_job.hdr[pls_pkg::EXT_M_IDX] = hdr_r[pls_pkg::EXT_M_IDX] | pls_pkg::EXT_M_MASK;
        end else begin
          q_job.hdr[pls_pkg::STD_M_IDX] = hdr_r[pls_pkg::STD_M_IDX] | pls_pkg::STD_M_MASK;
        end
      end
      q_job.last_idx = (cur_ff == '0) ? hl : '0;
      q_job.frag_end = fend;
      q_job.pkt_end  = closing;
      if (closing) begin
        frag_nxt = 1'b0;
        bp_nxt   = '0;
        ff_nxt   = '0;
      end else begin
        bp_nxt = cur_bp + LEN_W'(1);
        ff_nxt = fill_end ? '0 : cur_ff + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r  <= 1'b0;
      frag_r <= 1'b0;
      bp_r   <= '0;
      ff_r   <= '0;
      lh_r   <= '0;
    end else begin
      if (cfg_valid) begin
        ext_r <= cfg_extended_mode;
      end
      if (accept) begin
        frag_r <= frag_nxt;
        bp_r   <= bp_nxt;
        ff_r   <= ff_nxt;
        lh_r   <= lh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_we) begin
      hdr_r[bp_lo] <= in_data_byte;
    end
  end

endmodule

// ===== src/pls_queue.sv =====
// Short request queue between the front and back ends of the segmenter.
// Show-ahead read of the head entry. Depends on pls_pkg.
module pls_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pls_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pls_pkg::job_t head_job
);

  pls_pkg::job_t                mem_r [pls_pkg::QUEUE_DEPTH];
  logic [pls_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [pls_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full       = cnt_r == pls_pkg::QCNT_W'(pls_pkg::QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + pls_pkg::QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - pls_pkg::QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + pls_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pls_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/pls_back.sv =====
// Back end of the segmenter: steps through each queued request, one result
// per cycle unless stalled, into the output register. Depends on pls_pkg.
module pls_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  pls_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_fragment_end,
  output logic          out_packet_end,
  output logic          out_last_of_run
);

  logic [pls_pkg::IDX_W-1:0] idx_r;
  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_fragment_end_r, out_packet_end_r, out_last_of_run_r;
  logic                      adv, fire, at_last;
  logic [7:0]                byte_sel;

  assign adv     = ~out_valid_r | ~out_stall;
  assign fire    = adv & q_valid;
  assign at_last = idx_r == q_job.last_idx;
  assign q_pop   = fire & at_last;

  assign byte_sel = (at_last && !q_job.final_hdr) ? q_job.data
                                                  : q_job.hdr[idx_r[pls_pkg::HSEL_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (adv) begin
      out_valid_r <= q_valid;
      if (fire) begin
        idx_r <= at_last ? '0 : idx_r + pls_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r         <= byte_sel;
      out_fragment_end_r <= at_last & q_job.frag_end;
      out_packet_end_r   <= at_last & q_job.pkt_end;
      out_last_of_run_r  <= at_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_fragment_end = out_fragment_end_r;
  assign out_packet_end   = out_packet_end_r;
  assign out_last_of_run  = out_last_of_run_r;

  a_pkt_end_is_frag_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_packet_end_r |-> out_fragment_end_r)
    else $error("packet end without fragment end");

  a_frag_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fragment_end_r |-> out_last_of_run_r)
    else $error("fragment end inside a header copy");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> idx_r == '0)
    else $error("result index left nonzero with no request");

  a_index_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !fire |=> $stable(idx_r))
    else $error("result index moved while stalled");

endmodule

// ===== src/packet_layer_segmenter_core.sv =====
// Packet layer segmenter: splits long X.25 data packets into fragments
// with header copies and the more-data bit. Uses pls_front, pls_queue and
// pls_back; depends on pls_pkg.
//
// Input channel (in_valid / in_stall): one packet byte per request, with
// in_first_of_packet, in_last_of_packet and in_packet_length (read on the
// first byte). A request is taken at an edge with in_valid high and
// in_stall low. Output channel (out_valid / out_stall): one result byte per
// request with fragment and packet end marks and out_last_of_run.
// Configuration (cfg_valid / cfg_ready): cfg_extended_mode selects the
// 4-byte header; cfg_ready is always high; write only while idle.
// Throughput: one input byte per cycle for pass-through bytes; a fragmented
// packet adds a header copy per fragment at the output, sent by the
// single-result-per-cycle back end; the 4-entry request queue absorbs them
// until it fills and in_stall rises. A taken byte's request is queued, then
// its results go to the back end's output register. Header bytes held back
// give no result until the first payload byte. When out_stall is high the
// output register holds and the queue fills. Synchronous reset clears all
// control state and selects standard mode; no clearing pass is needed.
module packet_layer_segmenter_core #(
  parameter int FRAGMENT_DATA_BYTES = pls_pkg::FRAGMENT_DATA_BYTES_DEF,
  parameter int MAX_PACKET_BYTES    = pls_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_extended_mode,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_first_of_packet,
  input  logic                          in_last_of_packet,
  input  logic [pls_pkg::PKT_LEN_W-1:0] in_packet_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_fragment_end,
  output logic                          out_packet_end,
  output logic                          out_last_of_run
);

  logic          q_full, q_push, q_pop, q_valid;
  pls_pkg::job_t push_job, head_job;

  pls_front #(
    .FRAGMENT_DATA_BYTES (FRAGMENT_DATA_BYTES),
    .MAX_PACKET_BYTES    (MAX_PACKET_BYTES)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_extended_mode  (cfg_extended_mode),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_of_packet (in_first_of_packet),
    .in_last_of_packet  (in_last_of_packet),
    .in_packet_length   (in_packet_length),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_job              (push_job)
  );

  pls_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  pls_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (head_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_fragment_end (out_fragment_end),
    .out_packet_end   (out_packet_end),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
